@@ hw/rtl/cdf_pkg.sv @@
// Shared types, constants and helpers of the complex decimating FIR unit.
`timescale 1ns / 1ps

package cdf_pkg;

   // Sizes of the filter and its data words.
   localparam int MAX_TAPS        = 64;
   localparam int SAMPLE_BITS     = 16;
   localparam int COEF_BITS       = 16;
   localparam int COEF_INDEX_BITS = 6;
   localparam int TAP_IDX_BITS    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TAP_CNT_BITS    = $clog2(MAX_TAPS + 1);
   localparam int PROD_BITS       = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS        = PROD_BITS + TAP_IDX_BITS;
   localparam int ROUND_SHIFT     = COEF_BITS - 1;

   // Configuration register layout.
   localparam int DECIM_BITS    = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;

   typedef logic [CSR_IDX_BITS-1:0]      csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]     csr_data_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic [COEF_INDEX_BITS-1:0]    coef_index_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   localparam csr_index_type CSR_DECIM_FACTOR = csr_index_type'(0);
   localparam csr_index_type CSR_TAP_COUNT    = csr_index_type'(1);

   // Item kinds on the request channel.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   // Round half up to the sample format, then clamp to the signed range.
   function automatic sample_type round_sat(input acc_type acc);
      localparam logic signed [ACC_BITS:0] HALF =
         (ACC_BITS + 1)'(1 << (ROUND_SHIFT - 1));
      localparam logic signed [ACC_BITS:0] SAT_HI =
         (ACC_BITS + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
      localparam logic signed [ACC_BITS:0] SAT_LO = -SAT_HI - 1;
      logic signed [ACC_BITS:0] biased;
      logic signed [ACC_BITS:0] shifted;
      sample_type result;
      biased  = (ACC_BITS + 1)'(acc) + HALF;
      shifted = biased >>> ROUND_SHIFT;
      if (shifted > SAT_HI) begin
         result = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         result = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         result = shifted[SAMPLE_BITS-1:0];
      end
      return result;
   endfunction

endpackage

@@ hw/rtl/cdf_if.sv @@
// Channel interfaces of the complex decimating FIR unit.
`timescale 1ns / 1ps

// Request channel: sample items and coefficient write items.
interface cdf_req_if;
   import cdf_pkg::*;
   logic           valid;
   logic           ready;
   logic           cmd;
   sample_type     sample_i;
   sample_type     sample_q;
   coef_index_type coef_index;
   coef_type       coef_value;

   modport source (output valid, cmd, sample_i, sample_q, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, cmd, sample_i, sample_q, coef_index, coef_value,
                   output ready);
endinterface

// Result channel: one filtered I/Q item.
interface cdf_rsp_if;
   import cdf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type out_i;
   sample_type out_q;

   modport source (output valid, out_i, out_q, input ready);
   modport sink   (input valid, out_i, out_q, output ready);
endinterface

// Configuration write channel.
interface cdf_csr_if;
   import cdf_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/complex_decimating_fir_unit.sv @@
// Top level of the complex decimating FIR unit: memories, MAC pipeline and control.
//
// Channel   Direction  Carries
// req_bus   in         cmd, sample_i, sample_q, coef_index, coef_value
// rsp_bus   out        out_i, out_q
// csr_bus   in         index, data (decim_factor at 0, tap_count at 1)
//
// A coefficient item, or a sample item that yields no result, is done on acceptance.
// A sample item that yields a result goes through accept, one tap per cycle on the
// shared complex MAC, a drain of the pipeline and rounding (with no taps, accept
// and rounding only), which waits (holding off the input) while the output is full.
// Reset is synchronous; a fill count for the sample line and valid bits for the
// coefficients stand in for cleared stores, so there is no clearing pass.
`timescale 1ns / 1ps

module complex_decimating_fir_unit (
   input  logic    clock,
   input  logic    reset,
   cdf_req_if.sink   req_bus,
   cdf_rsp_if.source rsp_bus,
   cdf_csr_if.sink   csr_bus
);
   import cdf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MAC    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef logic [TAP_IDX_BITS-1:0] ptr_type;
   typedef logic [TAP_CNT_BITS-1:0] cnt_type;

   // Pointer step with wrap at the memory depth.
   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (TAP_CNT_BITS'(p) == cnt_type'(MAX_TAPS - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // Configuration registers.
   logic [DECIM_BITS-1:0] decim_factor_ff;
   cnt_type               tap_count_ff;

   // Control state.
   state_type             state_ff, state_in;
   cnt_type               k_ff, k_in;
   cnt_type               taps_ff, taps_in;
   cnt_type               fill_ff, fill_in;
   ptr_type               wr_ptr_ff, wr_ptr_in;
   ptr_type               rd_ptr_ff, rd_ptr_in;
   logic [DECIM_BITS-1:0] phase_ff, phase_in;
   logic [MAX_TAPS-1:0]   coef_vld_ff;

   // Pipeline valid and mask bits.
   logic v1_ff, v2_ff, m1_ff;

   // Memories and their read registers.
   logic [2*SAMPLE_BITS-1:0] sample_mem [MAX_TAPS];
   coef_type                 coef_mem   [MAX_TAPS];
   logic [2*SAMPLE_BITS-1:0] samp_rd_ff;
   coef_type                 coef_rd_ff;

   // Products and accumulators.
   logic signed [PROD_BITS-1:0] prod_i_ff, prod_q_ff;
   acc_type                     acc_i_ff, acc_q_ff;

   // Output register.
   logic       rsp_valid_ff;
   sample_type rsp_i_ff, rsp_q_ff;

   logic       req_acc;
   logic       is_sample;
   logic       clear_acc;
   logic       issue;
   logic       issue_ok;
   logic       load_out;
   cnt_type    taps_eff;
   ptr_type    new_ptr;
   ptr_type    base_ptr;
   cnt_type    age;
   logic [DECIM_BITS-1:0] factor;
   logic [DECIM_BITS-1:0] phase_nxt;
   logic signed [SAMPLE_BITS-1:0] op_i, op_q;
   coef_type   op_c;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign is_sample     = (req_bus.cmd == CMD_SAMPLE);
   assign issue         = (state_ff == ST_MAC);
   assign load_out      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   // Effective tap count and factor, and the phase that follows this sample.
   assign taps_eff  = (tap_count_ff > cnt_type'(MAX_TAPS)) ? cnt_type'(MAX_TAPS)
                                                           : tap_count_ff;
   assign factor    = (decim_factor_ff == '0) ? DECIM_BITS'(1) : decim_factor_ff;
   assign phase_nxt = phase_ff + DECIM_BITS'(1);

   // The oldest tap in use sits taps positions behind the next write slot.
   assign new_ptr  = ptr_inc(wr_ptr_ff);
   assign base_ptr = (TAP_CNT_BITS'(new_ptr) >= taps_eff)
                     ? TAP_IDX_BITS'(TAP_CNT_BITS'(new_ptr) - taps_eff)
                     : TAP_IDX_BITS'((TAP_CNT_BITS + 1)'(new_ptr) +
                                     (TAP_CNT_BITS + 1)'(MAX_TAPS) -
                                     (TAP_CNT_BITS + 1)'(taps_eff));

   // A tap counts only if its sample was ever written and its coefficient too.
   assign age      = taps_ff - cnt_type'(1) - k_ff;
   assign issue_ok = (age < fill_ff) && coef_vld_ff[k_ff[TAP_IDX_BITS-1:0]];

   // Next-state logic of the sequencer.
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      taps_in   = taps_ff;
      fill_in   = fill_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      phase_in  = phase_ff;
      clear_acc = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_sample) begin
               wr_ptr_in = new_ptr;
               if (fill_ff != cnt_type'(MAX_TAPS)) begin
                  fill_in = fill_ff + cnt_type'(1);
               end
               phase_in = (phase_nxt >= factor || phase_nxt == '0) ? '0 : phase_nxt;
               if (phase_ff == '0) begin
                  clear_acc = 1'b1;
                  taps_in   = taps_eff;
                  k_in      = '0;
                  rd_ptr_in = base_ptr;
                  state_in  = (taps_eff == '0) ? ST_FINISH : ST_MAC;
               end
            end
         end
         ST_MAC: begin
            k_in      = k_ff + cnt_type'(1);
            rd_ptr_in = ptr_inc(rd_ptr_ff);
            if (k_ff == taps_ff - cnt_type'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         k_ff            <= '0;
         taps_ff         <= '0;
         fill_ff         <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         phase_ff        <= '0;
         coef_vld_ff     <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         decim_factor_ff <= DECIM_BITS'(1);
         tap_count_ff    <= cnt_type'(51);
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         taps_ff   <= taps_in;
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         phase_ff  <= phase_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         if (req_acc && !is_sample && (int'(req_bus.coef_index) < MAX_TAPS)) begin
            coef_vld_ff[TAP_IDX_BITS'(req_bus.coef_index)] <= 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_DECIM_FACTOR: decim_factor_ff <= csr_bus.data[DECIM_BITS-1:0];
               CSR_TAP_COUNT:    tap_count_ff    <= cnt_type'(csr_bus.data[6:0]);
               default: begin
               end
            endcase
         end
      end
   end

   // Sample line as a ring buffer; one write on acceptance, one read per tap.
   always_ff @(posedge clock) begin
      if (req_acc && is_sample) begin
         sample_mem[wr_ptr_ff] <= {req_bus.sample_i, req_bus.sample_q};
      end
      samp_rd_ff <= sample_mem[rd_ptr_ff];
   end

   // Coefficient store.
   always_ff @(posedge clock) begin
      if (req_acc && !is_sample && (int'(req_bus.coef_index) < MAX_TAPS)) begin
         coef_mem[TAP_IDX_BITS'(req_bus.coef_index)] <= req_bus.coef_value;
      end
      coef_rd_ff <= coef_mem[k_ff[TAP_IDX_BITS-1:0]];
   end

   // Mask travels with the read data; unwritten entries act as zero.
   always_ff @(posedge clock) begin
      m1_ff <= issue_ok;
   end

   assign op_i = m1_ff ? samp_rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
   assign op_q = m1_ff ? samp_rd_ff[SAMPLE_BITS-1:0] : '0;
   assign op_c = m1_ff ? coef_rd_ff : '0;

   // Multiply stage, then accumulate stage.
   always_ff @(posedge clock) begin
      prod_i_ff <= op_i * op_c;
      prod_q_ff <= op_q * op_c;
      if (clear_acc) begin
         acc_i_ff <= '0;
         acc_q_ff <= '0;
      end else if (v2_ff) begin
         acc_i_ff <= acc_i_ff + ACC_BITS'(prod_i_ff);
         acc_q_ff <= acc_q_ff + ACC_BITS'(prod_q_ff);
      end
   end

   // Rounded and clamped result into the output register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_i_ff <= round_sat(acc_i_ff);
         rsp_q_ff <= round_sat(acc_q_ff);
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_i = rsp_i_ff;
   assign rsp_bus.out_q = rsp_q_ff;

   // The MAC pipeline is empty whenever the result is taken from the accumulators.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!v1_ff && !v2_ff))
      else $error("result formed while MAC pipeline busy");

   // A new result only appears after the rounding step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_FINISH))
      else $error("result valid without a finished computation");

   // The fill count never passes the line depth.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cnt_type'(MAX_TAPS))
      else $error("sample fill count out of range");

   // No tap is issued past the latched tap count.
   a_issue: assert property (@(posedge clock) disable iff (reset)
      issue |-> (k_ff < taps_ff))
      else $error("tap issued beyond tap count");

endmodule
